// File: sv/bpm3r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bpm3r_pkg;

  localparam int IN_W          = 24;
  localparam int OUT_W         = 24;
  localparam int FRAC_BITS_DEF = 24;

  localparam logic [31:0] ONE31   = 32'h8000_0000;
  localparam logic [63:0] ONE62   = 64'h4000_0000_0000_0000;
  localparam logic [23:0] OUT_MAX = 24'h40_0000;

  // 2u-1 of a U0.32 fraction, as a Q31 magnitude with a separate sign.
  function automatic logic [32:0] two_u_minus_one(input logic [31:0] u);
    logic [32:0] res;
    if (u >= ONE31) begin
      res = {1'b0, 1'b0, u[30:0]};
    end else begin
      res = {1'b1, ONE31 - u};
    end
    return res;
  endfunction

  // Saturate a magnitude to one and apply the sign.
  function automatic logic [OUT_W-1:0] to_out(input logic [23:0] mag, input logic neg);
    logic [23:0] m;
    m = (mag > OUT_MAX) ? OUT_MAX : mag;
    return neg ? (24'd0 - m) : m;
  endfunction

endpackage
`default_nettype wire

// File: sv/bpm3r_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bpm3r_in_if;
  import bpm3r_pkg::*;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] u_radius_a;
  logic [IN_W-1:0] u_radius_b;
  logic [IN_W-1:0] u_radius_c;
  logic [IN_W-1:0] u_polar;
  logic [IN_W-1:0] u_azim_x;
  logic [IN_W-1:0] u_azim_y;

  modport source (output valid, u_radius_a, u_radius_b, u_radius_c, u_polar,
                  u_azim_x, u_azim_y, input ready);
  modport sink (input valid, u_radius_a, u_radius_b, u_radius_c, u_polar,
                u_azim_x, u_azim_y, output ready);
endinterface
`default_nettype wire

// File: sv/bpm3r_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bpm3r_out_if;
  import bpm3r_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] coord_x;
  logic signed [OUT_W-1:0] coord_y;
  logic signed [OUT_W-1:0] coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface
`default_nettype wire

// File: sv/ball_point_max_of_three_radius.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Interface           Direction  Contents
// in_ch     bpm3r_in_if.sink    input      six U0.24 uniform draws
// out_ch    bpm3r_out_if.source output     x, y, z, signed 22 fraction bits
//
// The pipe has 38 register stages; while the output is not stalled, one bundle
// enters per cycle. The length is set by the square root and the two azimuth
// dividers, one result bit per stage over 32 stages, run side by side.
// Reset (synchronous, active low) clears only the stage valid bits.
// Each stage moves when it is empty or the stage after it moves, so a stall
// at the output fills bubbles first; rejected bundles leave the pipe unseen.
module ball_point_max_of_three_radius
  import bpm3r_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  bpm3r_in_if.sink     in_ch,
  bpm3r_out_if.source  out_ch
);

  localparam int          NST   = 38;
  localparam int          NIT   = 32;
  localparam int          SH    = 32 - FRAC_BITS;
  localparam logic [31:0] FMASK = (FRAC_BITS >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << FRAC_BITS) - 64'd1);

  typedef struct packed {
    logic [31:0] r32;
    logic [31:0] cm;
    logic        cneg;
    logic [31:0] am;
    logic        axneg;
    logic [30:0] ay;
  } s0_t;

  typedef struct packed {
    logic [63:0] cm2;
    logic [63:0] a2;
    logic [63:0] y2;
    logic [63:0] pxy;
    logic [22:0] zmag;
    logic [31:0] r32;
    logic        cneg;
    logic        axneg;
  } s1_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] sq_rem;
    logic [31:0] sq_root;
    logic [63:0] dv;
    logic [63:0] dx_rem;
    logic [31:0] dx_q;
    logic [63:0] dy_rem;
    logic [31:0] dy_q;
    logic [31:0] r32;
    logic [22:0] zmag;
    logic        zneg;
    logic        xneg;
    logic        axneg;
    logic        rej;
  } it_t;

  typedef struct packed {
    logic [31:0] rs;
    logic [31:0] cphi;
    logic [31:0] sphi;
    logic [22:0] zmag;
    logic        zneg;
    logic        xneg;
    logic        axneg;
    logic        rej;
  } s35_t;

  typedef struct packed {
    logic [23:0] xmag;
    logic [23:0] ymag;
    logic [22:0] zmag;
    logic        xneg;
    logic        zneg;
    logic        axneg;
    logic        rej;
  } s36_t;

  logic [NST-1:0]    v_r;
  logic [NST-1:0]    en;
  s0_t               s0_r, s0_nxt;
  s1_t               s1_r, s1_nxt;
  it_t               it_r [0:NIT];
  it_t               it_nxt [0:NIT];
  s35_t              s35_r, s35_nxt;
  s36_t              s36_r, s36_nxt;
  logic [OUT_W-1:0]  cx_r, cy_r, cz_r;

  function automatic logic [31:0] widen(input logic [IN_W-1:0] v);
    logic [31:0] w;
    w = 32'(v) & FMASK;
    return w << SH;
  endfunction

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ch.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int i = 1; i < NST - 1; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
      if (en[NST-1]) begin
        v_r[NST-1] <= v_r[NST-2] && !s36_r.rej;
      end
    end
  end

  // Stage 0: widen, radius maximum, map to signed magnitudes.
  always_comb begin
    logic [31:0] ra, rb, rc, up, ux, uy, mx;
    logic [32:0] tc, ta;
    ra = widen(in_ch.u_radius_a);
    rb = widen(in_ch.u_radius_b);
    rc = widen(in_ch.u_radius_c);
    up = widen(in_ch.u_polar);
    ux = widen(in_ch.u_azim_x);
    uy = widen(in_ch.u_azim_y);
    mx = (rb > ra) ? rb : ra;
    mx = (rc > mx) ? rc : mx;
    tc = two_u_minus_one(up);
    ta = two_u_minus_one(ux);
    s0_nxt.r32   = mx;
    s0_nxt.cm    = tc[31:0];
    s0_nxt.cneg  = tc[32];
    s0_nxt.am    = ta[31:0];
    s0_nxt.axneg = ta[32];
    s0_nxt.ay    = uy[31:1];
  end

  // Stage 1: products.
  always_comb begin
    logic [63:0] zp;
    zp = 64'(s0_r.r32) * 64'(s0_r.cm);
    s1_nxt.cm2   = 64'(s0_r.cm) * 64'(s0_r.cm);
    s1_nxt.a2    = 64'(s0_r.am) * 64'(s0_r.am);
    s1_nxt.y2    = 64'(s0_r.ay) * 64'(s0_r.ay);
    s1_nxt.pxy   = 64'(s0_r.am) * 64'(s0_r.ay);
    s1_nxt.zmag  = zp[63:41];
    s1_nxt.r32   = s0_r.r32;
    s1_nxt.cneg  = s0_r.cneg;
    s1_nxt.axneg = s0_r.axneg;
  end

  // Stage 2: sine radicand, azimuth norm, rejection test, divider operands.
  always_comb begin
    logic [32:0] c2;
    logic [31:0] d;
    logic [63:0] s;
    c2 = s1_r.cm2[63:31];
    d  = (c2 < 33'(ONE31)) ? 32'(33'(ONE31) - c2) : 32'd0;
    s  = s1_r.a2 + s1_r.y2;
    it_nxt[0].rad     = 64'(d) << 31;
    it_nxt[0].sq_rem  = '0;
    it_nxt[0].sq_root = '0;
    it_nxt[0].dv      = s;
    it_nxt[0].dx_rem  = (s1_r.a2 >= s1_r.y2) ? (s1_r.a2 - s1_r.y2) : (s1_r.y2 - s1_r.a2);
    it_nxt[0].xneg    = s1_r.a2 < s1_r.y2;
    it_nxt[0].dx_q    = '0;
    it_nxt[0].dy_rem  = s1_r.pxy << 1;
    it_nxt[0].dy_q    = '0;
    it_nxt[0].r32     = s1_r.r32;
    it_nxt[0].zmag    = s1_r.zmag;
    it_nxt[0].zneg    = s1_r.cneg;
    it_nxt[0].axneg   = s1_r.axneg;
    it_nxt[0].rej     = (s > ONE62) || (s == 64'd0);
  end

  // One square-root bit and one quotient bit of each divider per stage.
  for (genvar k = 0; k < NIT; k++) begin : g_iter
    always_comb begin
      logic [35:0] rt, tr;
      logic [63:0] tx, ty;
      it_nxt[k+1] = it_r[k];
      rt = {it_r[k].sq_rem, it_r[k].rad[63-2*k -: 2]};
      tr = {2'b00, it_r[k].sq_root, 2'b01};
      if (rt >= tr) begin
        it_nxt[k+1].sq_rem  = 34'(rt - tr);
        it_nxt[k+1].sq_root = {it_r[k].sq_root[30:0], 1'b1};
      end else begin
        it_nxt[k+1].sq_rem  = rt[33:0];
        it_nxt[k+1].sq_root = {it_r[k].sq_root[30:0], 1'b0};
      end
      // The first quotient bit compares the numerator without a shift.
      tx = (k == 0) ? it_r[k].dx_rem : (it_r[k].dx_rem << 1);
      ty = (k == 0) ? it_r[k].dy_rem : (it_r[k].dy_rem << 1);
      if (tx >= it_r[k].dv) begin
        it_nxt[k+1].dx_rem = tx - it_r[k].dv;
        it_nxt[k+1].dx_q   = {it_r[k].dx_q[30:0], 1'b1};
      end else begin
        it_nxt[k+1].dx_rem = tx;
        it_nxt[k+1].dx_q   = {it_r[k].dx_q[30:0], 1'b0};
      end
      if (ty >= it_r[k].dv) begin
        it_nxt[k+1].dy_rem = ty - it_r[k].dv;
        it_nxt[k+1].dy_q   = {it_r[k].dy_q[30:0], 1'b1};
      end else begin
        it_nxt[k+1].dy_rem = ty;
        it_nxt[k+1].dy_q   = {it_r[k].dy_q[30:0], 1'b0};
      end
    end
  end

  // Stage 35: radius times sine.
  always_comb begin
    logic [63:0] p;
    p = 64'(it_r[NIT].r32) * 64'(it_r[NIT].sq_root);
    s35_nxt.rs    = p[63:32];
    s35_nxt.cphi  = it_r[NIT].dx_q;
    s35_nxt.sphi  = it_r[NIT].dy_q;
    s35_nxt.zmag  = it_r[NIT].zmag;
    s35_nxt.zneg  = it_r[NIT].zneg;
    s35_nxt.xneg  = it_r[NIT].xneg && (it_r[NIT].dx_q != 32'd0);
    s35_nxt.axneg = it_r[NIT].axneg;
    s35_nxt.rej   = it_r[NIT].rej;
  end

  // Stage 36: scale the azimuth cosine and sine.
  always_comb begin
    logic [63:0] px, py;
    px = 64'(s35_r.rs) * 64'(s35_r.cphi);
    py = 64'(s35_r.rs) * 64'(s35_r.sphi);
    s36_nxt.xmag  = px[63:40];
    s36_nxt.ymag  = py[63:40];
    s36_nxt.zmag  = s35_r.zmag;
    s36_nxt.xneg  = s35_r.xneg;
    s36_nxt.zneg  = s35_r.zneg;
    s36_nxt.axneg = s35_r.axneg;
    s36_nxt.rej   = s35_r.rej;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r <= s0_nxt;
    end
    if (en[1]) begin
      s1_r <= s1_nxt;
    end
    for (int j = 0; j <= NIT; j++) begin
      if (en[2+j]) begin
        it_r[j] <= it_nxt[j];
      end
    end
    if (en[35]) begin
      s35_r <= s35_nxt;
    end
    if (en[36]) begin
      s36_r <= s36_nxt;
    end
    if (en[37]) begin
      cx_r <= to_out(s36_r.xmag, s36_r.xneg);
      cy_r <= to_out(s36_r.ymag, s36_r.axneg);
      cz_r <= to_out({1'b0, s36_r.zmag}, s36_r.zneg);
    end
  end

  assign out_ch.valid   = v_r[NST-1];
  assign out_ch.coord_x = cx_r;
  assign out_ch.coord_y = cy_r;
  assign out_ch.coord_z = cz_r;

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($signed(out_ch.coord_x) <= $signed(24'(OUT_MAX)) &&
                      $signed(out_ch.coord_x) >= -$signed(24'(OUT_MAX))))
    else $error("coord_x outside the unit range");

  a_reject_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NST-2] && s36_r.rej && en[NST-1]) |=> !out_ch.valid)
    else $error("rejected bundle reached the output");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2+NIT] |-> (it_r[NIT].sq_root <= ONE31))
    else $error("sine root above one");

  a_accept_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ch.ready)
    else $error("input refused with an empty first stage");

endmodule
`default_nettype wire
